/* hw/rtl/sqt_pkg.sv */
package sqt_pkg;

    typedef enum logic [4:0] {
        MODE_GLOBAL = 5'b00001,
        MODE_DQ     = 5'b00010,
        MODE_SQ     = 5'b00100,
        MODE_ENDED  = 5'b01000,
        MODE_ERROR  = 5'b10000
    } mode_t;

    localparam logic [1:0] KIND_WORD = 2'd0;
    localparam logic [1:0] KIND_DQ   = 2'd1;
    localparam logic [1:0] KIND_SQ   = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_OPEN_DQ = 2'd1;
    localparam logic [1:0] STATUS_OPEN_SQ = 2'd2;
    localparam logic [1:0] STATUS_SYNTAX  = 2'd3;

    localparam logic [7:0] CHR_NUL       = 8'h00;
    localparam logic [7:0] CHR_NEWLINE   = 8'h0a;
    localparam logic [7:0] CHR_SPACE     = 8'h20;
    localparam logic [7:0] CHR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHR_HASH      = 8'h23;
    localparam logic [7:0] CHR_DOLLAR    = 8'h24;
    localparam logic [7:0] CHR_SQUOTE    = 8'h27;
    localparam logic [7:0] CHR_SEMICOLON = 8'h3b;
    localparam logic [7:0] CHR_BACKSLASH = 8'h5c;
    localparam logic [7:0] CHR_BACKTICK  = 8'h60;

    typedef struct packed {
        mode_t      mode;
        logic       esc;
        logic       semi;
        logic       nonempty;
        logic [1:0] kind;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        mode:     MODE_GLOBAL,
        esc:      1'b0,
        semi:     1'b0,
        nonempty: 1'b0,
        kind:     KIND_WORD
    };

    typedef struct packed {
        logic       put_backslash;
        logic       close_token;
        logic [1:0] close_type;
        logic       put_semicolon;
        logic       put_byte;
        logic [7:0] byte_value;
        logic       line_done;
        logic [1:0] line_status;
    } tok_result_t;

endpackage

/* hw/rtl/sqt_step.sv */
module sqt_step (
    input  sqt_pkg::scan_state_t cur_state,
    input  logic [7:0]           in_byte,
    input  logic                 end_of_line,
    output sqt_pkg::scan_state_t nxt_state,
    output sqt_pkg::tok_result_t result
);
    import sqt_pkg::*;

    logic b_end;
    logic b_sep;
    logic dq_special;
    logic do_global;
    logic do_dq;

    assign b_end      = (in_byte == CHR_NUL) || (in_byte == CHR_HASH);
    assign b_sep      = (in_byte == CHR_SPACE) || (in_byte == CHR_SEMICOLON);
    assign dq_special = (in_byte == CHR_DOLLAR) || (in_byte == CHR_BACKTICK) ||
                        (in_byte == CHR_DQUOTE) || (in_byte == CHR_BACKSLASH) ||
                        (in_byte == CHR_NEWLINE);

    assign do_global = cur_state.semi ? (in_byte != CHR_SEMICOLON) : !cur_state.esc;
    assign do_dq     = !cur_state.esc || !dq_special;

    always_comb begin
        nxt_state = cur_state;
        result    = '0;
        if (end_of_line) begin
            result.put_backslash = (cur_state.mode == MODE_DQ) && cur_state.esc;
            if (cur_state.nonempty || result.put_backslash) begin
                result.close_token = 1'b1;
                result.close_type  = cur_state.kind;
            end
            result.put_semicolon = cur_state.semi;
            result.line_done     = 1'b1;
            case (cur_state.mode)
                MODE_ERROR: result.line_status = STATUS_SYNTAX;
                MODE_DQ:    result.line_status = STATUS_OPEN_DQ;
                MODE_SQ:    result.line_status = STATUS_OPEN_SQ;
                default:    result.line_status = STATUS_OK;
            endcase
            nxt_state = SCAN_RESET;
        end else begin
            case (cur_state.mode)
                MODE_GLOBAL: begin
                    if (cur_state.semi) begin
                        nxt_state.semi = 1'b0;
                        if (in_byte == CHR_SEMICOLON) begin
                            nxt_state.mode = MODE_ERROR;
                        end else begin
                            result.put_semicolon = 1'b1;
                        end
                    end else if (cur_state.esc) begin
                        nxt_state.esc = 1'b0;
                        if (in_byte == CHR_NUL) begin
                            nxt_state.mode = MODE_ENDED;
                        end else begin
                            result.put_byte    = 1'b1;
                            result.byte_value  = in_byte;
                            nxt_state.nonempty = 1'b1;
                        end
                    end
                    if (do_global) begin
                        if (b_end) begin
                            nxt_state.mode = MODE_ENDED;
                        end else if (in_byte == CHR_BACKSLASH) begin
                            nxt_state.esc = 1'b1;
                        end else if (in_byte == CHR_DQUOTE) begin
                            nxt_state.kind = KIND_DQ;
                            nxt_state.mode = MODE_DQ;
                        end else if (in_byte == CHR_SQUOTE) begin
                            nxt_state.kind = KIND_SQ;
                            nxt_state.mode = MODE_SQ;
                        end else if (b_sep) begin
                            if (cur_state.nonempty) begin
                                result.close_token = 1'b1;
                                result.close_type  = cur_state.kind;
                            end
                            nxt_state.nonempty = 1'b0;
                            nxt_state.kind     = KIND_WORD;
                            if (in_byte == CHR_SEMICOLON) begin
                                nxt_state.semi = 1'b1;
                            end
                        end else begin
                            nxt_state.kind     = KIND_WORD;
                            result.put_byte    = 1'b1;
                            result.byte_value  = in_byte;
                            nxt_state.nonempty = 1'b1;
                        end
                    end
                end
                MODE_DQ: begin
                    if (cur_state.esc) begin
                        nxt_state.esc = 1'b0;
                        if (dq_special) begin
                            result.put_byte    = 1'b1;
                            result.byte_value  = in_byte;
                            nxt_state.nonempty = 1'b1;
                        end else begin
                            result.put_backslash = 1'b1;
                            nxt_state.nonempty   = 1'b1;
                        end
                    end
                    if (do_dq) begin
                        if (b_end) begin
                            nxt_state.mode = MODE_ENDED;
                        end else if (in_byte == CHR_DQUOTE) begin
                            nxt_state.mode = MODE_GLOBAL;
                        end else if (in_byte == CHR_BACKSLASH) begin
                            nxt_state.esc = 1'b1;
                        end else begin
                            result.put_byte    = 1'b1;
                            result.byte_value  = in_byte;
                            nxt_state.nonempty = 1'b1;
                        end
                    end
                end
                MODE_SQ: begin
                    if (b_end) begin
                        nxt_state.mode = MODE_ENDED;
                    end else if (in_byte == CHR_SQUOTE) begin
                        nxt_state.mode = MODE_GLOBAL;
                    end else begin
                        result.put_byte    = 1'b1;
                        result.byte_value  = in_byte;
                        nxt_state.nonempty = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* hw/rtl/shell_quote_tokenizer_unit.sv */
// Shell command-line word tokenizer.
// Input channel (s_valid/s_ready): one line byte per transfer on s_in_byte, or
// s_end_of_line = 1 to close the line; the byte is ignored on an end-of-line
// transfer.
// Result channel (m_valid/m_ready): exactly one result per input transfer:
// backslash append, token close with type, separator, byte append, and the
// line status on the end-of-line result.
// A result is registered and presented in the cycle after its input transfer.
// Throughput: one transfer per cycle while results drain; the scanner state
// and the result register both update in the cycle of the input transfer,
// through one level of mode logic.
// Stall: s_ready is high while the result register is empty or being
// drained in the same cycle; a stalled result holds and backpressures input.
// Reset (aresetn low, synchronous): scanner returns to global scope with no
// held escape, semicolon or token, and the result register empties.
module shell_quote_tokenizer_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_line,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_put_backslash,
    output logic       m_close_token,
    output logic [1:0] m_close_type,
    output logic       m_put_semicolon,
    output logic       m_put_byte,
    output logic [7:0] m_byte_value,
    output logic       m_line_done,
    output logic [1:0] m_line_status
);
    import sqt_pkg::*;

    scan_state_t state_reg;
    scan_state_t state_next;
    tok_result_t result_reg;
    tok_result_t result_next;
    logic        m_valid_reg;
    logic        s_xfer;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    sqt_step u_step (
        .cur_state   (state_reg),
        .in_byte     (s_in_byte),
        .end_of_line (s_end_of_line),
        .nxt_state   (state_next),
        .result      (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SCAN_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_xfer) begin
                state_reg <= state_next;
            end
            if (s_ready) begin
                m_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            result_reg <= result_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_put_backslash = result_reg.put_backslash;
    assign m_close_token   = result_reg.close_token;
    assign m_close_type    = result_reg.close_type;
    assign m_put_semicolon = result_reg.put_semicolon;
    assign m_put_byte      = result_reg.put_byte;
    assign m_byte_value    = result_reg.byte_value;
    assign m_line_done     = result_reg.line_done;
    assign m_line_status   = result_reg.line_status;

`ifndef SYNTH
    a_eol_resets_state: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && s_end_of_line |=> state_reg == SCAN_RESET)
        else $error("scanner state not cleared after end of line");

    a_no_esc_and_semi: assert property (@(posedge aclk) disable iff (!aresetn)
        !(state_reg.esc && state_reg.semi))
        else $error("escape and semicolon held together");

    a_status_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_line_done |-> m_line_status == STATUS_OK)
        else $error("line status set without line done");

    a_byte_zero_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_put_byte |-> m_byte_value == 8'd0)
        else $error("byte value set without put byte");

    a_result_follows_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> m_valid)
        else $error("accepted transfer produced no result");
`endif

endmodule
